// File: rtl/mm3_pkg.sv
package mm3_pkg;

    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_N  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
    localparam int unsigned MM_R1 = 15;
    localparam int unsigned MM_R2 = 13;

    localparam logic [2:0] CNT_FULL = 3'd4;

    // Value of paddr bit 2 that selects the seed register.
    localparam logic SEED_SEL = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_BODY,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2
    } t_state;

    typedef struct packed {
        logic load;
        logic mix1;
        logic mix2;
        logic body;
        logic fin0;
        logic fin1;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_last;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[31-MM_R1:0], x[31:32-MM_R1]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[31-MM_R2:0], x[31:32-MM_R2]};
    endfunction

    // Keeps the low cnt bytes of a word; cnt is already limited to four.
    function automatic logic [31:0] mask_bytes(input logic [31:0] w, input logic [2:0] cnt);
        case (cnt)
            3'd0: mask_bytes = 32'd0;
            3'd1: mask_bytes = {24'd0, w[7:0]};
            3'd2: mask_bytes = {16'd0, w[15:0]};
            3'd3: mask_bytes = {8'd0, w[23:0]};
            default: mask_bytes = w;
        endcase
    endfunction

endpackage

// File: rtl/mm3_ctrl.sv
module mm3_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mm3_pkg::t_dp_stat i_stat,
    output mm3_pkg::t_dp_cmd  o_cmd
);
    import mm3_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MIX1;
                end
            end
            ST_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = ST_MIX2;
            end
            ST_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = ST_BODY;
            end
            ST_BODY: begin
                o_cmd.body = 1'b1;
                n_state    = i_stat.is_last ? ST_FIN0 : ST_IDLE;
            end
            ST_FIN0: begin
                o_cmd.fin0 = 1'b1;
                n_state    = ST_FIN1;
            end
            ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = ST_FIN2;
            end
            ST_FIN2: begin
                // Wait here until the output register can take the hash.
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mm3_datapath.sv
module mm3_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mm3_pkg::t_dp_cmd  i_cmd,
    output mm3_pkg::t_dp_stat o_stat,
    input  logic [31:0]       i_seed,
    input  logic [31:0]       i_word,
    input  logic [2:0]        i_count,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_out_hash
);
    import mm3_pkg::*;

    logic [31:0] r_word;
    logic [2:0]  r_cnt;
    logic        r_last;
    logic [31:0] r_k;
    logic [31:0] r_h;
    logic [31:0] r_len;
    logic        r_in_key;
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic [2:0]  w_cnt;
    logic [31:0] w_rot;
    logic [31:0] w_fold;
    logic [31:0] w_av0;
    logic [31:0] w_av1;

    always_comb begin
        if (!i_last) begin
            w_cnt = CNT_FULL;
        end else if (i_count inside {[3'd5:3'd7]}) begin
            w_cnt = CNT_FULL;
        end else begin
            w_cnt = i_count;
        end
    end

    assign w_rot  = rotl13(r_h ^ r_k);
    assign w_fold = r_h ^ r_len;
    assign w_av0  = w_fold ^ (w_fold >> 16);
    assign w_av1  = r_h ^ (r_h >> 13);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_in_key    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_len    <= r_len + {29'd0, w_cnt};
                r_in_key <= 1'b1;
            end else if (i_cmd.fin0) begin
                r_len    <= '0;
                r_in_key <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= mask_bytes(i_word, w_cnt);
            r_cnt  <= w_cnt;
            r_last <= i_last;
            // A new key starts from the seed; a key in progress keeps its hash.
            if (!r_in_key) begin
                r_h <= i_seed;
            end
        end
        if (i_cmd.mix1) begin
            r_k <= r_word * MM_C1;
        end
        if (i_cmd.mix2) begin
            r_k <= rotl15(r_k) * MM_C2;
        end
        if (i_cmd.body) begin
            if (r_cnt == CNT_FULL) begin
                r_h <= (w_rot << 2) + w_rot + MM_N;
            end else if (r_cnt != 3'd0) begin
                r_h <= r_h ^ r_k;
            end
        end
        if (i_cmd.fin0) begin
            r_h <= w_av0 * MM_F1;
        end
        if (i_cmd.fin1) begin
            r_h <= w_av1 * MM_F2;
        end
        if (i_cmd.emit) begin
            r_out_hash <= r_h ^ (r_h >> 16);
        end
    end

    assign o_stat.is_last  = r_last;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_hash      = r_out_hash;

endmodule

// File: rtl/murmur3_32_stream_hash_unit.sv
// An item passes the MIX1, MIX2 and BODY states, a last item then FIN0, FIN1 and FIN2, where
// it waits while the output register is busy before its hash is registered; no new item is taken
// until then. Each 32x32 multiply (two for chunk mix, two for avalanche) has its own state.
// A finished hash waits in the output register while the next item is taken in.
// Reset (synchronous, active low) clears the seed to zero, the key state and the output valid.
module murmur3_32_stream_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_word [31:0]
    input  logic [2:0]  s_axis_tuser,   // byte_count [2:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // hash_value [31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mm3_pkg::*;

    logic [31:0] r_seed;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic        w_seed_wr;

    assign pready    = 1'b1;
    assign w_seed_wr = psel && penable && pwrite && (paddr[2] == SEED_SEL);
    assign prdata    = (paddr[2] == SEED_SEL) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_seed_wr) begin
            r_seed <= pwdata;
        end
    end

    mm3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mm3_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_seed      (r_seed),
        .i_word      (s_axis_tdata),
        .i_count     (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_hash  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("block still ready right after taking an item");

    a_body_item_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |-> ##4 s_axis_tready)
        else $error("non-last item did not finish in four cycles");

    a_last_item_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |-> ##4 !s_axis_tready)
        else $error("last item skipped the finalization steps");

    a_seed_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seed_wr |=> r_seed == $past(pwdata))
        else $error("seed register did not take the written value");
`endif

endmodule
